// ===== sv/sfo_pkg.sv =====
// Shared constants, widths and control structures of the spectral flux onset unit.
package sfo_pkg;

    localparam int BINS        = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int CFG_W   = 11;
    localparam int FLUX_W  = 26;
    localparam int ADDR_W  = $clog2(BINS);
    localparam int POS_W   = $clog2(BINS + 1);
    localparam int CMP_W   = (POS_W > CFG_W) ? POS_W : CFG_W;
    localparam int MAG_W   = SAMPLE_BITS;
    localparam int RAD_W   = 2 * SAMPLE_BITS;
    localparam int REM_W   = SAMPLE_BITS + 2;
    localparam int STEP_W  = $clog2(SAMPLE_BITS);

    localparam logic [CFG_W-1:0]  BINS_USED_RESET = CFG_W'(1024);
    localparam logic [FLUX_W-1:0] FLUX_MAX        = {FLUX_W{1'b1}};

    typedef struct packed {
        logic clear_step;
        logic load;
        logic root_init;
        logic root_step;
        logic update;
        logic emit;
    } sfo_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic root_done;
        logic last;
        logic out_free;
    } sfo_status_t;

endpackage

// ===== sv/spectral_flux_onset_unit.sv =====
// Spectral flux onset unit: top level joining the controller and the datapath.
//
// Input channel (in_valid, in_stall, bin_re, bin_im, last_bin) carries one
// spectrum bin per beat, lowest bin first; last_bin closes the frame.
// Output channel (out_valid, out_stall, flux) carries one beat per frame: the
// sum of positive magnitude increases over the lowest bins_used bins. cfg_we
// with cfg_data writes bins_used; the user writes it only while the unit is
// idle, since the block leaves this rule unenforced.
// Each bin passes through these steps before the next bin can be taken: the
// accepting cycle, which registers the squares of both components; an init
// step that forms the radicand and reads the stored magnitude; the bit-serial
// square root, one result bit per cycle; and an update step. A bin that closes
// a frame then takes an emit step for the hand-over to the output register,
// which waits while the output register still holds a stalled beat. The emit
// step loads the flux beat into the output register. After reset the store
// of magnitudes is cleared in a pass over all 1024 entries, one entry per
// cycle, with in_stall held high; configuration writes still land.
// A waiting flux beat does not block new bins; only the end of the next
// frame waits until the receiver has taken the previous beat.
module spectral_flux_onset_unit
    import sfo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [MAG_W-1:0]  bin_re,
    input  logic signed [MAG_W-1:0]  bin_im,
    input  logic                     last_bin,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FLUX_W-1:0]        flux
);

    sfo_cmd_t    cmd;
    sfo_status_t status;

    sfo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sfo_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .bin_re    (bin_re),
        .bin_im    (bin_im),
        .last_bin  (last_bin),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .flux      (flux),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/sfo_ctrl.sv =====
// Controller state machine that sequences the clearing pass and the per-bin work.
module sfo_ctrl
    import sfo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  sfo_status_t status,
    output sfo_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_ROOT,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // The sum is handed over only once the output register can take it.
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/sfo_datapath.sv =====
// Datapath: squares, bit-serial square root, magnitude store, flux sum and output register.
module sfo_datapath
    import sfo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic signed [MAG_W-1:0]  bin_re,
    input  logic signed [MAG_W-1:0]  bin_im,
    input  logic                     last_bin,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [FLUX_W-1:0]        flux,
    input  sfo_cmd_t                 cmd,
    output sfo_status_t              status
);

    logic [MAG_W-1:0]  mem [BINS];

    logic [CFG_W-1:0]  bins_used_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [FLUX_W-1:0] sum_reg;
    logic [FLUX_W-1:0] sum_next;
    logic [RAD_W-1:0]  sq_re_reg;
    logic [RAD_W-1:0]  sq_im_reg;
    logic              last_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [MAG_W-1:0]  root_reg;
    logic [MAG_W-1:0]  root_next;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  old_reg;
    logic              out_valid_reg;
    logic [FLUX_W-1:0] flux_reg;

    logic [MAG_W-1:0]  abs_re;
    logic [MAG_W-1:0]  abs_im;
    logic [CMP_W-1:0]  limit;
    logic              active;
    logic [ADDR_W-1:0] pos_addr;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [MAG_W-1:0]  diff;
    logic [FLUX_W:0]   sum_wide;

    // The most negative sample maps onto 2^(MAG_W-1), which still fits unsigned.
    assign abs_re = bin_re[MAG_W-1] ? MAG_W'(-bin_re) : MAG_W'(bin_re);
    assign abs_im = bin_im[MAG_W-1] ? MAG_W'(-bin_im) : MAG_W'(bin_im);

    assign limit    = (CMP_W'(bins_used_reg) > CMP_W'(BINS)) ? CMP_W'(BINS)
                                                            : CMP_W'(bins_used_reg);
    assign active   = CMP_W'(pos_reg) < limit;
    assign pos_addr = pos_reg[ADDR_W-1:0];

    // One result bit per step: bring down two radicand bits and try to subtract.
    assign rem_shift = {rem_reg[MAG_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb
    begin
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[MAG_W-2:0], 1'b0};
        end
    end

    assign diff     = root_reg - old_reg;
    assign sum_wide = {1'b0, sum_reg} + (FLUX_W + 1)'(diff);

    always_comb
    begin
        sum_next = sum_reg;
        if (active && (root_reg > old_reg))
        begin
            sum_next = sum_wide[FLUX_W] ? FLUX_MAX : sum_wide[FLUX_W-1:0];
        end
    end

    assign status.clear_done = (clr_addr_reg == ADDR_W'(BINS - 1));
    assign status.root_done  = (step_reg == STEP_W'(SAMPLE_BITS - 1));
    assign status.last       = last_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign flux      = flux_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.update && active)
        begin
            mem[pos_addr] <= root_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_init && active)
        begin
            old_reg <= mem[pos_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_re_reg <= RAD_W'(abs_re) * RAD_W'(abs_re);
            sq_im_reg <= RAD_W'(abs_im) * RAD_W'(abs_im);
            last_reg  <= last_bin;
        end
        if (cmd.root_init)
        begin
            rad_reg  <= sq_re_reg + sq_im_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.emit)
        begin
            flux_reg <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_used_reg <= BINS_USED_RESET;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bins_used_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.root_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.root_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.update)
            begin
                sum_reg <= sum_next;
                if (pos_reg < POS_W'(BINS))
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else if (cmd.emit)
            begin
                sum_reg <= '0;
                pos_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/sfo_checker.sv =====
// Port-level checker of the spectral flux onset unit and its bind.
module sfo_checker
    import sfo_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [FLUX_W-1:0] flux
);

    // A stalled flux beat stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(flux))
        else $error("flux beat changed or vanished while stalled");

    // Each bin keeps the unit busy for the following cycle.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    // A flux beat never appears the cycle after a bin is taken.
    a_no_early_flux: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("flux beat appeared too early");

    // The clearing pass holds off input right after reset.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall)
        else $error("input open during the clearing pass");

endmodule

bind spectral_flux_onset_unit sfo_checker u_sfo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flux      (flux)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the spectral flux onset unit with its own flux predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sfo_pkg::*;

    localparam logic signed [MAG_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [MAG_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam int DRAIN_LIMIT     = 100000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 24;
    localparam int LONG_FRAME_BINS = BINS + 6;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic signed [MAG_W-1:0] re;
        logic signed [MAG_W-1:0] im;
        logic                    last;
    } bin_beat_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [MAG_W-1:0] bin_re = '0;
    logic signed [MAG_W-1:0] bin_im = '0;
    logic                    last_bin = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [FLUX_W-1:0]       flux;

    bin_beat_t         pending_bins[$];
    logic [FLUX_W-1:0] flux_expected[$];

    // Predictor state.
    logic [MAG_W-1:0] prev_mag [0:BINS-1];
    int               bin_pos;
    longint           flux_acc;
    logic [CFG_W-1:0] bins_limit;

    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    bit  bin_taken = 1'b0;
    int  mismatches = 0;
    int  bins_seen = 0;
    int  frames_checked = 0;

    spectral_flux_onset_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bin_re    (bin_re),
        .bin_im    (bin_im),
        .last_bin  (last_bin),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flux      (flux)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [MAG_W-1:0] floor_root(input logic [RAD_W-1:0] radicand);
        logic [MAG_W-1:0] root;
        logic [MAG_W-1:0] trial;
        root = '0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            trial = root | (MAG_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= longint'(radicand))
                root = trial;
        end
        return root;
    endfunction

    task automatic fold_bin(input logic signed [MAG_W-1:0] re, input logic signed [MAG_W-1:0] im,
                            input logic last);
        longint           power;
        logic [MAG_W-1:0] mag;
        int               limit;
        limit = (bins_limit > BINS) ? BINS : int'(bins_limit);
        if (bin_pos < limit)
        begin
            power = longint'(re) * longint'(re) + longint'(im) * longint'(im);
            mag = floor_root(power[RAD_W-1:0]);
            if (mag > prev_mag[bin_pos])
            begin
                flux_acc += longint'(mag) - longint'(prev_mag[bin_pos]);
                if (flux_acc > longint'(FLUX_MAX))
                    flux_acc = longint'(FLUX_MAX);
            end
            prev_mag[bin_pos] = mag;
        end
        if (bin_pos < BINS)
            bin_pos++;
        if (last)
        begin
            flux_expected.push_back(flux_acc[FLUX_W-1:0]);
            flux_acc = 0;
            bin_pos = 0;
        end
    endtask

    task automatic log_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    // The predictor follows every accepted input beat and every register write.
    always @(posedge clk)
    begin : watch_ports
        logic [FLUX_W-1:0] want;
        if (!rst_n)
        begin
            for (int k = 0; k < BINS; k++)
                prev_mag[k] = '0;
            bin_pos = 0;
            flux_acc = 0;
            bins_limit = BINS_USED_RESET;
            bin_taken = 1'b0;
        end
        else
        begin
            if (cfg_we)
                bins_limit = cfg_data;
            bin_taken = in_valid && !in_stall;
            if (bin_taken)
            begin
                fold_bin(bin_re, bin_im, last_bin);
                bins_seen++;
            end
            if (out_valid && !out_stall)
            begin
                if (flux_expected.size() == 0)
                    log_failure($sformatf("flux beat %0d with nothing expected", flux));
                else
                begin
                    want = flux_expected.pop_front();
                    frames_checked++;
                    if (flux !== want)
                        log_failure($sformatf("flux expected %0d, got %0d", want, flux));
                end
            end
        end
    end

    always @(negedge clk)
    begin : feed_bins
        bin_beat_t beat;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || bin_taken)
        begin
            if (pending_bins.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                beat = pending_bins.pop_front();
                in_valid <= 1'b1;
                bin_re   <= beat.re;
                bin_im   <= beat.im;
                last_bin <= beat.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic signed [MAG_W-1:0] pick_component();
        logic [MAG_W-1:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            2, 3:
            begin
                v = MAG_W'($urandom_range(255));
                v = v - 16'd128;
            end
            default: v = MAG_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_bin(input logic signed [MAG_W-1:0] re, input logic signed [MAG_W-1:0] im,
                             input logic last);
        bin_beat_t b;
        b.re = re;
        b.im = im;
        b.last = last;
        pending_bins.push_back(b);
    endtask

    task automatic queue_random_frames(input int item_target, input int longest);
        int queued;
        int length;
        queued = 0;
        while (queued < item_target)
        begin
            length = ($urandom_range(7) == 0) ? $urandom_range(longest, 1) : $urandom_range(12, 1);
            for (int k = 0; k < length; k++)
                queue_bin(pick_component(), pick_component(), k == length - 1);
            queued += length;
        end
    endtask

    // Returns once every bin has been taken and every flux beat has come back, or once the drain limit runs out.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((pending_bins.size() != 0 || in_valid || flux_expected.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bins_used(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                sender_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                sender_idle_pct = 74;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                recv_stall_pct = 74;
            end
            default:
            begin
                sender_idle_pct = 13;
                recv_stall_pct = 13;
            end
        endcase
    endtask

    initial
    begin
        int limit;
        int longest;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limit: extreme magnitudes, then a frame of rises and falls, then a one-bin frame.
        queue_bin(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        queue_bin(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_bin(16'sd0, 16'sd0, 1'b0);
        queue_bin(SAMPLE_MIN, 16'sd0, 1'b0);
        queue_bin(16'sd0, SAMPLE_MAX, 1'b0);
        queue_bin(16'sd1, -16'sd1, 1'b1);
        queue_bin(16'sd0, 16'sd0, 1'b0);
        queue_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_bin(-16'sd1, 16'sd0, 1'b0);
        queue_bin(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_bin(16'sd0, 16'sd0, 1'b0);
        queue_bin(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        queue_bin(16'sd5, -16'sd12, 1'b1);
        wait_drained();

        // A limit of zero compares nothing and must leave the stored magnitudes alone.
        write_bins_used(CFG_W'(0));
        queue_bin(16'sd100, 16'sd100, 1'b0);
        queue_bin(-16'sd7, 16'sd24, 1'b0);
        queue_bin(16'sd3, 16'sd4, 1'b1);
        wait_drained();

        // A limit above the store size behaves as the store size.
        write_bins_used({CFG_W{1'b1}});
        queue_bin(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        queue_bin(16'sd0, 16'sd0, 1'b1);
        wait_drained();

        // Bins past a small limit are ignored.
        write_bins_used(CFG_W'(2));
        queue_bin(16'sd30000, -16'sd30000, 1'b0);
        queue_bin(16'sd1, 16'sd1, 1'b0);
        queue_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_bin(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        queue_bin(16'sd9, 16'sd40, 1'b1);
        wait_drained();

        // One frame longer than the store, so the bin counter saturates.
        write_bins_used(CFG_W'(BINS));
        for (int k = 0; k < LONG_FRAME_BINS; k++)
            queue_bin(pick_component(), pick_component(), k == LONG_FRAME_BINS - 1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: limit = BINS;
                1: limit = (1 << CFG_W) - 1;
                2: limit = 1;
                3: limit = 17;
                4: limit = 0;
                5: limit = $urandom_range(40, 1);
                6: limit = BINS;
                default: limit = 5;
            endcase
            longest = (limit + 4 > 40) ? 40 : limit + 4;
            // Short frames during the hold-off make sure frames end while it lasts.
            if (p == 0)
                longest = 12;
            write_bins_used(CFG_W'(limit));
            set_idling(idle_mode_t'(p % 4));
            if (p == 0)
            begin
                // The output is held off long enough for the unit to back up its input.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            queue_random_frames(PHASE_ITEMS, longest);
            wait_drained();
        end

        if (flux_expected.size() != 0)
            log_failure($sformatf("%0d flux beats never arrived", flux_expected.size()));
        $display("sent %0d spectrum bins and compared %0d flux beats", bins_seen, frames_checked);
        $display("bin limits 0 to 2047, a saturating long frame, four idling mixes, one hold-off");
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
